// File: hdl/fep_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and field helpers for the flash erase planner.
package fep_pkg;

    localparam int ERASER_TYPES_DEF = 6;
    localparam int MAX_OPS_DEF      = 64;
    localparam int ADDR_BITS_DEF    = 24;

    localparam int NUM_ERASER_REGS = 6;
    localparam int IDX_W           = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int SIZE_W          = 25;
    localparam int CNT_FIELD_W     = 14;
    localparam int BASE_W          = 24;
    localparam int CUR_W           = 26;

    localparam logic [CFG_IDX_W-1:0] REG_EXACT_FIT = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_START  = 3'd1;
    localparam logic [2:0] ST_GAP       = 3'd2;
    localparam logic [2:0] ST_NOT_EXACT = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;

    typedef struct packed {
        logic [23:0] request_start;
        logic [24:0] request_length;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [24:0] op_address;
        logic [24:0] op_size;
        logic [2:0]  eraser_index;
        logic [23:0] covered_start;
        logic [25:0] covered_length;
        logic        last;
    } op_t;

    function automatic logic [BASE_W-1:0] er_base(input logic [63:0] r);
        return r[23:0];
    endfunction

    function automatic logic [SIZE_W-1:0] er_size(input logic [63:0] r);
        return r[48:24];
    endfunction

    function automatic logic [CNT_FIELD_W-1:0] er_count(input logic [63:0] r);
        return r[62:49];
    endfunction

    function automatic logic er_enable(input logic [63:0] r);
        return r[63];
    endfunction

endpackage

// File: hdl/fep_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module fep_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fep_pkg::CUR_W-1:0]   dividend,
    input  logic [fep_pkg::CUR_W-1:0]   divisor,
    output logic [fep_pkg::CUR_W-1:0]   quotient,
    output logic [fep_pkg::CUR_W-1:0]   remainder,
    output logic                        done
);
    localparam int W   = fep_pkg::CUR_W;
    localparam int CW  = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

endmodule

// File: hdl/flash_erase_planner.sv
`timescale 1ns / 1ps
// Flash erase planner top level: sequencer, op buffer and output register.
//
//  channel | signals                                      | moves
//  --------+----------------------------------------------+--------------------------
//  in      | in_valid, in_ready, in_data (req_t)          | one erase request
//  out     | out_valid, out_ready, out_data (op_t)        | one command or one error
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | eraser / exact_fit writes
//
// Every eligible eraser probe (enabled, nonzero size, base at or below the address)
// runs the shared divider through S_SCAN, S_DIV and S_EVAL; any other eraser is skipped
// in S_SCAN. Each emitted command is then read (S_RD) and loaded (S_LOAD) as out_ready
// allows; in_ready is low throughout.
// Reset clears all eraser registers (all disabled) and the sequencer.
// out_ready low holds the output register and stalls the sequencer in S_LOAD or S_ERR;
// the next request is taken once the last result is loaded.
module flash_erase_planner
#(
    parameter int ERASER_TYPES = fep_pkg::ERASER_TYPES_DEF,
    parameter int MAX_OPS      = fep_pkg::MAX_OPS_DEF,
    parameter int ADDR_BITS    = fep_pkg::ADDR_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fep_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fep_pkg::op_t                   out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data
);
    localparam int IW   = fep_pkg::IDX_W;
    localparam int SW   = fep_pkg::SIZE_W;
    localparam int BW   = fep_pkg::BASE_W;
    localparam int CW   = fep_pkg::CUR_W;
    localparam int NW   = $clog2(MAX_OPS + 1);
    localparam int AW   = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int EW   = IW + SW;
    localparam logic [BW-1:0] ADDR_MASK = BW'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_PLACE = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_LOAD  = 4'd7;
    localparam logic [3:0] S_ERR   = 4'd8;

    logic [63:0]    er_reg [fep_pkg::NUM_ERASER_REGS];
    logic           exact_fit_reg;

    logic [3:0]     state_reg, state_next;
    logic [IW-1:0]  e_reg, e_next;
    logic           later_reg, later_next;
    logic [BW-1:0]  start_reg, start_next;
    logic [CW-1:0]  end_reg, end_next;
    logic [CW-1:0]  cursor_reg, cursor_next;
    logic [BW-1:0]  first_reg, first_next;
    logic           best_valid_reg, best_valid_next;
    logic [IW-1:0]  best_idx_reg, best_idx_next;
    logic [CW-1:0]  best_cost_reg, best_cost_next;
    logic [SW-1:0]  best_size_reg, best_size_next;
    logic [BW-1:0]  best_bs_reg, best_bs_next;
    logic [NW-1:0]  count_reg, count_next;
    logic [NW-1:0]  k_reg, k_next;
    logic [2:0]     err_reg, err_next;
    logic           out_valid_reg, out_valid_next;
    fep_pkg::op_t   out_data_reg, out_data_next;

    logic [EW-1:0]  mem [MAX_OPS];
    logic [EW-1:0]  rd_data_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata;
    logic           mem_re;

    logic           div_start, div_done;
    logic [CW-1:0]  div_q, div_r;

    logic [63:0]    cur_er;
    logic [BW-1:0]  cur_base;
    logic [SW-1:0]  cur_size;
    logic [CW-1:0]  probe_addr;
    logic           eligible;
    logic [CW-1:0]  bs;
    logic [CW:0]    blk_end;
    logic [CW:0]    over;
    logic [CW-1:0]  cost;
    logic           in_range;
    logic           out_free;
    logic [IW-1:0]  rd_idx;
    logic [CW-1:0]  cov_len;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fep_pkg::NUM_ERASER_REGS; i++)
            begin
                er_reg[i] <= '0;
            end
            exact_fit_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index < IW'(fep_pkg::NUM_ERASER_REGS))
            begin
                er_reg[cfg_index] <= cfg_data;
            end
            else if (cfg_index == fep_pkg::REG_EXACT_FIT)
            begin
                exact_fit_reg <= cfg_data[0];
            end
        end
    end

    // probe datapath for eraser e_reg at the current address
    assign cur_er     = (e_reg < IW'(fep_pkg::NUM_ERASER_REGS)) ? er_reg[e_reg] : '0;
    assign cur_base   = fep_pkg::er_base(cur_er) & ADDR_MASK;
    assign cur_size   = fep_pkg::er_size(cur_er);
    assign probe_addr = later_reg ? cursor_reg : CW'(start_reg);
    assign eligible   = fep_pkg::er_enable(cur_er) && (cur_size != '0)
                        && (CW'(cur_base) <= probe_addr);
    assign div_start  = (state_reg == S_SCAN) && (e_reg < IW'(ERASER_TYPES)) && eligible;

    // the cursor offset can exceed the size width, so the divider runs at cursor width
    fep_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (probe_addr - CW'(cur_base)),
        .divisor   (CW'(cur_size)),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    assign in_range = (div_q < CW'(fep_pkg::er_count(cur_er)));
    assign bs       = probe_addr - div_r;
    assign blk_end  = (CW+1)'(bs) + (CW+1)'(cur_size);
    assign over     = (blk_end >= (CW+1)'(end_reg)) ? (blk_end - (CW+1)'(end_reg)) : '0;
    assign cost     = CW'((CW+1)'(CW'(start_reg) - bs) + over);

    assign rd_idx   = rd_data_reg[EW-1:SW];
    assign cov_len  = cursor_reg - CW'(first_reg);

    always_comb
    begin
        state_next      = state_reg;
        e_next          = e_reg;
        later_next      = later_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        cursor_next     = cursor_reg;
        first_next      = first_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_cost_next  = best_cost_reg;
        best_size_next  = best_size_reg;
        best_bs_next    = best_bs_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = {best_idx_reg, SW'(cursor_reg)};
        mem_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next      = in_data.request_start & ADDR_MASK;
                    end_next        = CW'(in_data.request_start & ADDR_MASK)
                                      + CW'(in_data.request_length);
                    later_next      = 1'b0;
                    e_next          = '0;
                    best_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (e_reg >= IW'(ERASER_TYPES))
                begin
                    state_next = S_PLACE;
                end
                else if (eligible)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    e_next = e_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (in_range)
                begin
                    if (!later_reg)
                    begin
                        if (!best_valid_reg || cost < best_cost_reg
                            || (cost == best_cost_reg && cur_size > best_size_reg))
                        begin
                            best_valid_next = 1'b1;
                            best_idx_next   = e_reg;
                            best_cost_next  = cost;
                            best_size_next  = cur_size;
                            best_bs_next    = BW'(bs);
                        end
                    end
                    else if (div_r == '0
                             && (CW+1)'(cursor_reg) + (CW+1)'(cur_size) <= (CW+1)'(end_reg)
                             && (!best_valid_reg || cur_size > best_size_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = e_reg;
                        best_size_next  = cur_size;
                    end
                end
                e_next     = e_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_PLACE:
            begin
                if (!best_valid_reg)
                begin
                    err_next   = later_reg ? fep_pkg::ST_GAP : fep_pkg::ST_NO_START;
                    state_next = S_ERR;
                end
                else if (!later_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = '0;
                    mem_wdata   = {best_idx_reg, SW'(best_bs_reg)};
                    count_next  = NW'(1);
                    first_next  = best_bs_reg;
                    cursor_next = CW'(best_bs_reg) + CW'(best_size_reg);
                    state_next  = S_CHECK;
                end
                else if (count_reg >= NW'(MAX_OPS))
                begin
                    err_next   = fep_pkg::ST_TOO_MANY;
                    state_next = S_ERR;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = count_reg[AW-1:0];
                    count_next  = count_reg + 1'b1;
                    cursor_next = cursor_reg + CW'(best_size_reg);
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cursor_reg < end_reg)
                begin
                    later_next      = 1'b1;
                    e_next          = '0;
                    best_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else if (exact_fit_reg && (first_reg != start_reg || cursor_reg != end_reg))
                begin
                    err_next   = fep_pkg::ST_NOT_EXACT;
                    state_next = S_ERR;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = fep_pkg::ST_OK;
                    out_data_next.op_address    = rd_data_reg[SW-1:0];
                    out_data_next.op_size       =
                        (rd_idx < IW'(fep_pkg::NUM_ERASER_REGS))
                        ? fep_pkg::er_size(er_reg[rd_idx]) : '0;
                    out_data_next.eraser_index  = rd_idx;
                    out_data_next.covered_start = first_reg;
                    out_data_next.covered_length = cov_len;
                    out_data_next.last          = (k_reg + 1'b1 == count_reg);
                    if (k_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next        = '0;
                    out_data_next.status = err_reg;
                    out_data_next.last   = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            e_reg          <= '0;
            later_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            count_reg      <= '0;
            k_reg          <= '0;
            err_reg        <= fep_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            cursor_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            e_reg          <= e_next;
            later_reg      <= later_next;
            best_valid_reg <= best_valid_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            cursor_reg     <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        first_reg     <= first_next;
        best_idx_reg  <= best_idx_next;
        best_cost_reg <= best_cost_next;
        best_size_reg <= best_size_next;
        best_bs_reg   <= best_bs_next;
        out_data_reg  <= out_data_next;
    end

    // op buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[k_reg[AW-1:0]];
        end
    end

endmodule

// File: hdl/fep_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the flash erase planner, bound to the top level.
module fep_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic          out_valid,
    input  logic          out_ready,
    input  fep_pkg::op_t  out_data
);
    // an error request is a single result
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != fep_pkg::ST_OK |-> out_data.last)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != fep_pkg::ST_OK
        |-> out_data.op_size == '0 && out_data.op_address == '0
            && out_data.covered_length == '0)
        else $error("error result carries data");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while planning");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind flash_erase_planner fep_checker u_fep_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/flash_erase_planner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flash erase planner: directed table, then random phases.
module flash_erase_planner_tb;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PHASES    = 5;
    localparam int PHASE_ITEMS    = 24;
    localparam logic [fep_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        int          cfg_set;
        logic [23:0] start;
        logic [24:0] length;
        bit          typed;
        logic [2:0]  status;
    } table_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    fep_pkg::req_t in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    fep_pkg::op_t  out_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [fep_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]   cfg_data = '0;

    logic [63:0]   eraser_cfg [fep_pkg::NUM_ERASER_REGS];
    bit            exact_mode;
    fep_pkg::op_t  planned_ops [$];
    int            mismatches;
    bit            no_gaps;
    bit            hold_out;
    int            idle_cycles = 0;

    flash_erase_planner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit block_hit(input logic [63:0] r, input logic [63:0] a,
                                     output logic [63:0] bs);
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] c;
        b = r[23:0];
        s = r[48:24];
        c = r[62:49];
        bs = '0;
        if (!r[63] || s == 0)
            return 1'b0;
        if (a < b || a >= b + s * c)
            return 1'b0;
        bs = b + ((a - b) / s) * s;
        return 1'b1;
    endfunction

    task automatic push_error(input logic [2:0] code);
        fep_pkg::op_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        planned_ops.push_back(r);
    endtask

    // Plans one request and queues the commands it should produce, or its error result.
    task automatic plan_request(input logic [23:0] start, input logic [24:0] length);
        logic [63:0] st;
        logic [63:0] fin;
        logic [63:0] bs;
        logic [63:0] sz;
        logic [63:0] over;
        logic [63:0] cost;
        logic [63:0] bcost;
        logic [63:0] bsize;
        logic [63:0] first;
        logic [63:0] cur;
        logic [63:0] psize;
        logic [2:0]  op_idx [64];
        logic [24:0] op_adr [64];
        int          best;
        int          pick;
        int          n;
        fep_pkg::op_t r;
        st = start;
        fin = st + length;
        best = -1;
        bcost = 0;
        bsize = 0;
        first = 0;
        for (int e = 0; e < fep_pkg::NUM_ERASER_REGS; e++)
        begin
            if (!block_hit(eraser_cfg[e], st, bs))
                continue;
            sz = eraser_cfg[e][48:24];
            over = (bs + sz >= fin) ? bs + sz - fin : 0;
            cost = (st - bs) + over;
            if (best < 0 || cost < bcost || (cost == bcost && sz > bsize))
            begin
                best = e;
                bcost = cost;
                bsize = sz;
                first = bs;
            end
        end
        if (best < 0)
        begin
            push_error(fep_pkg::ST_NO_START);
            return;
        end
        op_idx[0] = best[2:0];
        op_adr[0] = first[24:0];
        n = 1;
        cur = first + bsize;
        while (cur < fin)
        begin
            pick = -1;
            psize = 0;
            for (int e = 0; e < fep_pkg::NUM_ERASER_REGS; e++)
            begin
                if (!block_hit(eraser_cfg[e], cur, bs) || bs != cur)
                    continue;
                sz = eraser_cfg[e][48:24];
                if (cur + sz > fin)
                    continue;
                if (pick < 0 || sz > psize)
                begin
                    pick = e;
                    psize = sz;
                end
            end
            if (pick < 0)
            begin
                push_error(fep_pkg::ST_GAP);
                return;
            end
            if (n >= fep_pkg::MAX_OPS_DEF)
            begin
                push_error(fep_pkg::ST_TOO_MANY);
                return;
            end
            op_idx[n] = pick[2:0];
            op_adr[n] = cur[24:0];
            n++;
            cur += psize;
        end
        if (exact_mode && (first != st || cur != fin))
        begin
            push_error(fep_pkg::ST_NOT_EXACT);
            return;
        end
        for (int k = 0; k < n; k++)
        begin
            r.status = fep_pkg::ST_OK;
            r.op_address = op_adr[k];
            r.op_size = eraser_cfg[op_idx[k]][48:24];
            r.eraser_index = op_idx[k];
            r.covered_start = first[23:0];
            r.covered_length = 26'(cur - first);
            r.last = (k + 1 == n);
            planned_ops.push_back(r);
        end
    endtask

    // Leaves cfg_valid high; cfg_release lowers it after a batch of writes.
    task automatic cfg_write(input logic [fep_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < fep_pkg::NUM_ERASER_REGS)
            eraser_cfg[idx] = value;
        else if (idx == fep_pkg::REG_EXACT_FIT)
            exact_mode = value[0];
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pack_eraser(input bit en, input logic [13:0] cnt,
                                                input logic [24:0] sz, input logic [23:0] b);
        return {en, cnt, sz, b};
    endfunction

    task automatic load_erasers(input logic [63:0] e0, input logic [63:0] e1,
                                input logic [63:0] e2, input logic [63:0] e3,
                                input logic [63:0] e4, input logic [63:0] e5,
                                input bit ex);
        cfg_write(3'd0, e0);
        cfg_write(3'd1, e1);
        cfg_write(3'd2, e2);
        cfg_write(3'd3, e3);
        cfg_write(3'd4, e4);
        cfg_write(3'd5, e5);
        cfg_write(fep_pkg::REG_EXACT_FIT, {63'd0, ex});
    endtask

    task automatic apply_set(input int set_id);
        case (set_id)
            1:
            begin
                load_erasers(pack_eraser(1, 14'd4096, 25'h1000, 24'h0),
                             pack_eraser(1, 14'd256, 25'h10000, 24'h0),
                             pack_eraser(0, 14'd1, 25'h100, 24'h200000),
                             pack_eraser(1, 14'd5, 25'h0, 24'h0),
                             pack_eraser(1, 14'd8, 25'h100000, 24'h800000),
                             pack_eraser(1, 14'd16, 25'h800, 24'h300000), 1'b0);
                cfg_write(REG_UNUSED, 64'hDEAD_BEEF_0123_4567);
            end
            2:
                load_erasers(pack_eraser(1, 14'd4, 25'h10000, 24'h0),
                             pack_eraser(1, 14'd100, 25'h1, 24'h100000),
                             '0, '0, '0, '0, 1'b0);
            3:
                cfg_write(fep_pkg::REG_EXACT_FIT, 64'd1);
            4:
                load_erasers('0, '0, '0, '0, '0, {64{1'b1}}, 1'b0);
            default:
                ;
        endcase
        cfg_release();
    endtask

    task automatic wait_drained();
        while (planned_ops.size() != 0)
            @(posedge clk);
        // the planner may still be finishing its last request
        repeat (40) @(posedge clk);
    endtask

    // Called at an acceptance edge (or when in_valid is low); never lowers and raises together.
    task automatic send_request(input logic [23:0] start, input logic [24:0] length,
                                input bit typed, input logic [2:0] status);
        int gap;
        fep_pkg::req_t rq;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rq.request_start = start;
        rq.request_length = length;
        in_data <= rq;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            push_error(status);
        else
            plan_request(start, length);
    endtask

    task automatic random_config();
        logic [63:0] r;
        for (int e = 0; e < fep_pkg::NUM_ERASER_REGS; e++)
        begin
            if ($urandom_range(0, 9) == 0)
                r = {$urandom, $urandom};
            else
                r = pack_eraser($urandom_range(0, 5) != 0, 14'($urandom_range(1, 64)),
                                25'd1 << $urandom_range(10, 14),
                                24'($urandom_range(0, 15)) << 16);
            cfg_write(e[fep_pkg::CFG_IDX_W-1:0], r);
        end
        cfg_write(fep_pkg::REG_EXACT_FIT, {63'd0, $urandom_range(0, 2) == 0});
        cfg_release();
    endtask

    task automatic random_request();
        logic [63:0] r;
        logic [63:0] sz;
        logic [63:0] span;
        logic [63:0] st;
        logic [24:0] ln;
        r = eraser_cfg[$urandom_range(0, fep_pkg::NUM_ERASER_REGS - 1)];
        sz = r[48:24];
        span = sz * r[62:49];
        if ($urandom_range(0, 99) < 15)
        begin
            send_request(24'($urandom), 25'($urandom_range(0, 25'h1FF_FFFF)), 1'b0,
                         fep_pkg::ST_OK);
            return;
        end
        if (span == 0 || span > 64'hFF_FFFF)
            span = 64'h10000;
        st = r[23:0] + 64'($urandom_range(0, 32'(span - 1)));
        if (sz != 0 && $urandom_range(0, 1))
            st = r[23:0] + ((st - r[23:0]) / sz) * sz;
        if ($urandom_range(0, 1) && sz != 0 && sz <= 64'h4000)
            ln = 25'(sz * $urandom_range(0, 4));
        else
            ln = 25'($urandom_range(0, 16'hC000));
        send_request(st[23:0], ln, 1'b0, fep_pkg::ST_OK);
    endtask

    table_row_t directed [] = '{
        '{0, 24'h000000, 25'h0000001, 1, fep_pkg::ST_NO_START},
        '{0, 24'hFFFFFF, 25'h1000000, 1, fep_pkg::ST_NO_START},
        '{1, 24'h001234, 25'h0000000, 0, fep_pkg::ST_OK},
        '{1, 24'h000000, 25'h0020000, 0, fep_pkg::ST_OK},
        '{1, 24'h010800, 25'h0003000, 0, fep_pkg::ST_OK},
        '{1, 24'h300400, 25'h0002000, 0, fep_pkg::ST_OK},
        '{1, 24'h800000, 25'h0300000, 0, fep_pkg::ST_OK},
        '{1, 24'h000000, 25'h1000000, 1, fep_pkg::ST_TOO_MANY},
        '{1, 24'h200000, 25'h0000004, 0, fep_pkg::ST_OK},
        '{2, 24'h000000, 25'h0048000, 1, fep_pkg::ST_GAP},
        '{2, 24'h040000, 25'h0000001, 1, fep_pkg::ST_NO_START},
        '{2, 24'h100000, 25'h0000040, 0, fep_pkg::ST_OK},
        '{2, 24'h100000, 25'h0000041, 1, fep_pkg::ST_TOO_MANY},
        '{2, 24'h100005, 25'h0000000, 0, fep_pkg::ST_OK},
        '{3, 24'h000100, 25'h0000010, 1, fep_pkg::ST_NOT_EXACT},
        '{3, 24'h010000, 25'h0020000, 0, fep_pkg::ST_OK},
        '{3, 24'h008000, 25'h0000100, 1, fep_pkg::ST_NOT_EXACT},
        '{4, 24'hFFFFFF, 25'h0000001, 0, fep_pkg::ST_OK},
        '{4, 24'hFFFFFF, 25'h1FFFFFF, 0, fep_pkg::ST_OK},
        '{4, 24'hFFFFFE, 25'h0000001, 1, fep_pkg::ST_NO_START}
    };

    // Result side: random stalls, one long hold-off on request.
    initial
    begin
        int stall;
        fep_pkg::op_t want;
        @(posedge rst_n);
        forever
        begin
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (planned_ops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", out_data);
            end
            else
            begin
                want = planned_ops.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int cur_set;
        foreach (eraser_cfg[i])
            eraser_cfg[i] = '0;
        exact_mode = 1'b0;
        mismatches = 0;
        no_gaps = 1'b0;
        hold_out = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_set = 0;
        foreach (directed[i])
        begin
            if (directed[i].cfg_set != cur_set)
            begin
                in_valid <= 1'b0;
                wait_drained();
                cur_set = directed[i].cfg_set;
                apply_set(cur_set);
            end
            send_request(directed[i].start, directed[i].length,
                         directed[i].typed, directed[i].status);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // sender pauses here until every queued command has come back
            in_valid <= 1'b0;
            wait_drained();
            random_config();
            no_gaps = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 4)
                    hold_out = 1'b1;
                random_request();
            end
        end
        in_valid <= 1'b0;
        while (planned_ops.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && planned_ops.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
hdl/fep_pkg.sv
hdl/fep_divider.sv
hdl/flash_erase_planner.sv
hdl/fep_checker.sv
tb/flash_erase_planner_tb.sv
